[src/sliding_window_maximum_top_defines.svh]
// Assertion macros used by the sliding window maximum control block (swm_ctrl)
`ifndef SLIDING_WINDOW_MAXIMUM_TOP_DEFINES_SVH
`define SLIDING_WINDOW_MAXIMUM_TOP_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off while i_rst_n is low
`define SWM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off while i_rst_n is low
`define SWM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/swm_pkg.sv]
// Package: shared constants for the sliding window maximum filter
`timescale 1ns / 1ps

package swm_pkg;

    localparam int WINDOW_MAX_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int CFG_W           = 7;

endpackage

[src/sliding_window_maximum_top.sv]
// Top level: sliding window maximum filter built as a chain of window cells
//
// Input channel: i_in_valid / o_in_stall carry one item (i_sample, i_restart).
// An item is taken at a rising edge with i_in_valid high and o_in_stall low.
// Output channel: o_out_valid / i_out_stall carry o_window_max.
// Window length is written through i_cfg_we / i_cfg_window_len; the user must
// do so only while idle, the block does not check it; zero acts as one, values
// above WINDOW_MAX act as WINDOW_MAX. Each taken sample shifts into the head
// of the cell chain. If the sequence now holds at least window-length
// samples, a search token walks the whole chain, one cell per cycle, folding
// in the newest window-length samples. The result passes through the inject
// register, every cell of the chain, a hold register and the output register.
// An item that yields a result blocks input until that result has left the
// hold register; an item without a result does not block. i_restart starts
// a new sequence at that item. A result held in the output register under
// i_out_stall does not block the next item; a second finished result waits
// in the hold register and input stalls until it moves on.
// Reset (synchronous, active low) empties the pipeline, clears the fill
// count and sets the window length to one; stored samples are not cleared.
`timescale 1ns / 1ps

module sliding_window_maximum_top
    import swm_pkg::*;
#(
    parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic        [CFG_W-1:0]       i_cfg_window_len,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_restart,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [SAMPLE_BITS-1:0] o_window_max
);

    localparam int LEN_W = $clog2(WINDOW_MAX + 1);

    logic                          w_shift;
    logic signed [SAMPLE_BITS-1:0] w_s  [0:WINDOW_MAX];
    logic                          w_tv [0:WINDOW_MAX];
    logic        [LEN_W-1:0]       w_tl [0:WINDOW_MAX];
    logic signed [SAMPLE_BITS-1:0] w_tm [0:WINDOW_MAX];

    assign w_s[0] = i_sample;

    swm_ctrl #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS),
        .LEN_W       (LEN_W)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_window_len (i_cfg_window_len),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_restart        (i_restart),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_window_max     (o_window_max),
        .o_shift          (w_shift),
        .o_inj_valid      (w_tv[0]),
        .o_inj_left       (w_tl[0]),
        .o_inj_max        (w_tm[0]),
        .i_tail_valid     (w_tv[WINDOW_MAX]),
        .i_tail_left      (w_tl[WINDOW_MAX]),
        .i_tail_max       (w_tm[WINDOW_MAX])
    );

    for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
        swm_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .LEN_W       (LEN_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_shift     (w_shift),
            .i_sample    (w_s[g]),
            .o_sample    (w_s[g+1]),
            .i_tok_valid (w_tv[g]),
            .i_tok_left  (w_tl[g]),
            .i_tok_max   (w_tm[g]),
            .o_tok_valid (w_tv[g+1]),
            .o_tok_left  (w_tl[g+1]),
            .o_tok_max   (w_tm[g+1])
        );
    end

endmodule

[src/swm_cell.sv]
// One window cell: holds a sample and folds it into a passing search token
`timescale 1ns / 1ps

module swm_cell
    import swm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int LEN_W       = 7
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_shift,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic signed [SAMPLE_BITS-1:0] o_sample,
    input  logic                          i_tok_valid,
    input  logic        [LEN_W-1:0]       i_tok_left,
    input  logic signed [SAMPLE_BITS-1:0] i_tok_max,
    output logic                          o_tok_valid,
    output logic        [LEN_W-1:0]       o_tok_left,
    output logic signed [SAMPLE_BITS-1:0] o_tok_max
);

    logic signed [SAMPLE_BITS-1:0] r_s;
    logic                          r_tv;
    logic        [LEN_W-1:0]       r_tl;
    logic signed [SAMPLE_BITS-1:0] r_tm;
    logic                          w_take;

    assign w_take = (i_tok_left != '0) && (r_s > i_tok_max);

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_s <= i_sample;
        end
        r_tl <= (i_tok_left != '0) ? i_tok_left - LEN_W'(1) : i_tok_left;
        r_tm <= w_take ? r_s : i_tok_max;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tv <= 1'b0;
        end else begin
            r_tv <= i_tok_valid;
        end
    end

    assign o_sample    = r_s;
    assign o_tok_valid = r_tv;
    assign o_tok_left  = r_tl;
    assign o_tok_max   = r_tm;

endmodule

[src/swm_ctrl.sv]
// Control: window length register, fill count, scan launch and output register
`timescale 1ns / 1ps
`include "sliding_window_maximum_top_defines.svh"

module swm_ctrl
    import swm_pkg::*;
#(
    parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int LEN_W       = $clog2(WINDOW_MAX + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic        [CFG_W-1:0]       i_cfg_window_len,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_restart,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [SAMPLE_BITS-1:0] o_window_max,
    output logic                          o_shift,
    output logic                          o_inj_valid,
    output logic        [LEN_W-1:0]       o_inj_left,
    output logic signed [SAMPLE_BITS-1:0] o_inj_max,
    input  logic                          i_tail_valid,
    input  logic        [LEN_W-1:0]       i_tail_left,
    input  logic signed [SAMPLE_BITS-1:0] i_tail_max
);

    localparam int               CMP_W    = (CFG_W > LEN_W) ? CFG_W : LEN_W;
    localparam logic [LEN_W-1:0] FILL_MAX = LEN_W'(WINDOW_MAX);

    logic        [CFG_W-1:0]       r_len;
    logic        [LEN_W-1:0]       r_fill;
    logic        [LEN_W-1:0]       n_fill;
    logic        [LEN_W-1:0]       w_base;
    logic        [LEN_W-1:0]       w_len_eff;
    logic        [CMP_W-1:0]       w_len_cmp;
    logic                          r_scan;
    logic                          r_inj;
    logic                          r_res_valid;
    logic signed [SAMPLE_BITS-1:0] r_res;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out;
    logic                          w_accept;
    logic                          w_due;
    logic                          w_out_free;

    assign w_len_cmp = CMP_W'(r_len);

    always_comb begin
        priority if (r_len == '0) begin
            w_len_eff = LEN_W'(1);
        end else if (w_len_cmp > CMP_W'(WINDOW_MAX)) begin
            w_len_eff = FILL_MAX;
        end else begin
            w_len_eff = LEN_W'(w_len_cmp);
        end
    end

    assign o_in_stall = r_scan | r_res_valid;
    assign w_accept   = i_in_valid & ~o_in_stall;
    assign w_base     = i_restart ? '0 : r_fill;
    assign n_fill     = (w_base < FILL_MAX) ? w_base + LEN_W'(1) : w_base;
    assign w_due      = (n_fill >= w_len_eff);
    assign w_out_free = ~r_out_valid | ~i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= CFG_W'(1);
            r_fill      <= '0;
            r_scan      <= 1'b0;
            r_inj       <= 1'b0;
            r_res_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_len <= i_cfg_window_len;
            end
            if (w_accept) begin
                r_fill <= n_fill;
            end
            r_inj <= w_accept & w_due;
            if (w_accept && w_due) begin
                r_scan <= 1'b1;
            end else if (i_tail_valid) begin
                r_scan <= 1'b0;
            end
            if (i_tail_valid) begin
                r_res_valid <= 1'b1;
            end else if (w_out_free) begin
                r_res_valid <= 1'b0;
            end
            if (w_out_free) begin
                r_out_valid <= r_res_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tail_valid) begin
            r_res <= i_tail_max;
        end
        if (w_out_free && r_res_valid) begin
            r_out <= r_res;
        end
    end

    assign o_shift      = w_accept;
    assign o_inj_valid  = r_inj;
    assign o_inj_left   = w_len_eff;
    assign o_inj_max    = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    assign o_out_valid  = r_out_valid;
    assign o_window_max = r_out;

    `SWM_ASSERT_NOW(a_tail_in_scan, i_tail_valid, r_scan, "token left the chain outside a scan")
    `SWM_ASSERT_NOW(a_tail_spent, i_tail_valid, i_tail_left == '0, "token exits with cells unsearched")
    `SWM_ASSERT_NEXT(a_scan_start, w_accept && w_due, r_scan && r_inj, "scan did not start")
    `SWM_ASSERT_NOW(a_fill_cap, 1'b1, r_fill <= FILL_MAX, "fill count beyond window depth")
    `SWM_ASSERT_NOW(a_res_after_scan, r_res_valid, !r_scan, "result held while scan still running")

endmodule

[test/tb_sliding_window_maximum_top.sv]
// Testbench for the sliding window maximum filter: random and directed items, scoreboard
`timescale 1ns / 1ps

module tb_sliding_window_maximum_top;
    import swm_pkg::*;

    localparam int SB         = SAMPLE_BITS_DEF;
    localparam int WMAX       = WINDOW_MAX_DEF;
    localparam int RAND_ITEMS = 1750;
    localparam int LONG_HOLD  = 300;
    localparam int CYCLE_CAP  = 1000000;

    localparam logic signed [SB-1:0] S_MIN  = 16'sh8000;
    localparam logic signed [SB-1:0] S_MAX  = 16'sh7FFF;
    localparam logic signed [SB-1:0] S_ZERO = 16'sh0000;
    localparam logic signed [SB-1:0] S_NEG1 = 16'shFFFF;

    class window_max_scoreboard;
        logic signed [SB-1:0] history [WMAX];
        int                   head;
        int                   fill;
        logic [CFG_W-1:0]     win_len;
        logic signed [SB-1:0] expected_max [$];
        int                   errors;

        function new();
            head    = 0;
            fill    = 0;
            win_len = 1;
            errors  = 0;
        endfunction

        function void set_window_len(logic [CFG_W-1:0] v);
            win_len = v;
        endfunction

        function void note_sample(logic signed [SB-1:0] s, logic restart);
            int                   last;
            int                   len;
            int                   idx;
            logic signed [SB-1:0] best;
            if (restart) begin
                fill = 0;
                head = 0;
            end
            last          = head;
            history[last] = s;
            head          = (last == WMAX - 1) ? 0 : last + 1;
            if (fill < WMAX) fill++;
            len = (win_len == 0) ? 1 : (win_len > WMAX) ? WMAX : int'(win_len);
            if (fill < len) return;
            best = s;
            for (int i = 1; i < len; i++) begin
                idx = (last + WMAX - i) % WMAX;
                if (history[idx] > best) best = history[idx];
            end
            expected_max = {expected_max, best};
        endfunction

        function void check_max(logic signed [SB-1:0] got);
            logic signed [SB-1:0] want;
            if (expected_max.size() == 0) begin
                $display("%0t: unexpected window_max, expected none, actual %0d", $time, got);
                errors++;
                return;
            end
            want = expected_max.pop_front();
            if (got !== want) begin
                $display("%0t: window_max mismatch, expected %0d, actual %0d", $time, want, got);
                errors++;
            end
        endfunction

        function int pending();
            return expected_max.size();
        endfunction
    endclass

    logic                 i_clk            = 1'b0;
    logic                 i_rst_n          = 1'b0;
    logic                 i_cfg_we         = 1'b0;
    logic [CFG_W-1:0]     i_cfg_window_len = '0;
    logic                 i_in_valid       = 1'b0;
    logic                 o_in_stall;
    logic signed [SB-1:0] i_sample         = '0;
    logic                 i_restart        = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_stall      = 1'b0;
    logic signed [SB-1:0] o_window_max;

    window_max_scoreboard sb;
    bit                   no_idle  = 1'b0;
    bit                   hold_req = 1'b0;
    int                   cycles   = 0;

    sliding_window_maximum_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_window_len (i_cfg_window_len),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_sample         (i_sample),
        .i_restart        (i_restart),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_window_max     (o_window_max)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_max(o_window_max);
        if (i_rst_n && i_in_valid && !o_in_stall) sb.note_sample(i_sample, i_restart);
    end

    function automatic int pick_gap();
        return no_idle ? 0 : int'($urandom_range(0, 5));
    endfunction

    function automatic logic signed [SB-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 3))
                    0: return S_MIN;
                    1: return S_MAX;
                    2: return S_ZERO;
                    default: return S_NEG1;
                endcase
            end
            default: return SB'($urandom);
        endcase
    endfunction

    // receiver: random stall before each item, or one long hold on request
    initial begin
        int n;
        forever begin
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                n = pick_gap();
                if (n > 0) begin
                    i_out_stall <= 1'b1;
                    repeat (n) @(posedge i_clk);
                end
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    task automatic send_item(input logic signed [SB-1:0] s, input logic r);
        int n;
        n = pick_gap();
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample   <= s;
        i_restart  <= r;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic set_window(input logic [CFG_W-1:0] v);
        wait_drained();
        repeat (WMAX + 8) @(posedge i_clk);
        i_cfg_we         <= 1'b1;
        i_cfg_window_len <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_window_len(v);
    endtask

    initial begin
        int               sent;
        int               phase;
        int               count;
        int               span;
        logic [CFG_W-1:0] len;
        logic             r;

        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset length of one, field extremes
        send_item(S_MAX, 1'b1);
        send_item(S_MIN, 1'b0);
        send_item(S_ZERO, 1'b0);
        send_item(S_NEG1, 1'b0);
        send_item(16'sh0001, 1'b0);
        // zero length acts as one
        set_window(7'd0);
        send_item(S_MIN, 1'b0);
        send_item(S_MAX, 1'b1);
        // length three, restart mid-stream
        set_window(7'd3);
        send_item(S_MIN, 1'b1);
        send_item(S_MIN, 1'b0);
        send_item(S_MIN, 1'b0);
        send_item(S_MAX, 1'b0);
        send_item(S_NEG1, 1'b0);
        send_item(S_ZERO, 1'b0);
        send_item(16'sh0005, 1'b1);
        send_item(16'sh0007, 1'b0);
        send_item(-16'sh0003, 1'b0);
        // shorter window mid-sequence
        set_window(7'd2);
        send_item(S_NEG1, 1'b0);
        send_item(S_MIN, 1'b0);

        sent  = 0;
        phase = 0;
        while (sent < RAND_ITEMS) begin
            phase++;
            case (phase)
                1: len = 7'd127;
                2: len = 7'd0;
                3: len = 7'd2;
                4: len = 7'd64;
                5: len = 7'd3;
                6: len = 7'd65;
                default: begin
                    case ($urandom_range(0, 9))
                        0: len = CFG_W'($urandom_range(60, 127));
                        1: len = CFG_W'($urandom_range(9, 64));
                        default: len = CFG_W'($urandom_range(0, 8));
                    endcase
                end
            endcase
            set_window(len);
            span    = (len > WMAX) ? WMAX : int'(len);
            no_idle = (phase == 3) || ($urandom_range(0, 3) == 0);
            if (phase == 3) hold_req = 1'b1;
            count = (span >= 32) ? $urandom_range(90, 140) : $urandom_range(30, 70);
            for (int k = 0; k < count; k++) begin
                if (k == 0)
                    r = 1'($urandom_range(0, 1));
                else if (span >= 32)
                    r = ($urandom_range(0, 199) == 0);
                else
                    r = ($urandom_range(0, 15) == 0);
                if (phase == 5 && k == count / 2) wait_drained();
                send_item(rand_sample(), r);
                sent++;
            end
        end

        wait_drained();
        repeat (WMAX + 10) @(posedge i_clk);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
